[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain invariant, checked on every clock edge out of reset
`define SCC_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define SCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/scc_pkg.sv]
`timescale 1ns / 1ps

package scc_pkg;

  // angle format and solenoid count are tied to the fixed field widths
  localparam int ANGLE_BITS = 14;
  localparam int SOLENOIDS  = 4;
  localparam int WINDOW_DEF = 50;

  localparam int RAW_W    = 12;
  localparam int CAL_W    = 14;
  localparam int THR_W    = 13;
  localparam int LEAD_W   = 12;
  localparam int PERIOD_W = 16;
  localparam int DIR_W    = 2;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 5;

  localparam logic [THR_W-1:0]    SPIN_THR_RST   = THR_W'(22);
  localparam logic [LEAD_W-1:0]   LEAD_RST       = LEAD_W'(455);
  localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST = PERIOD_W'(999);

  // pwm: floor(n * (period + 1) / 14742) by reciprocal multiply
  localparam int PWM_N_W      = 14;
  localparam int PWM_P1_W     = PERIOD_W + 1;
  localparam int PWM_PROD_W   = PWM_N_W + PWM_P1_W;
  localparam int PWM_DIV      = 14742;
  localparam int PWM_SH       = PWM_PROD_W + 14;
  localparam int PWM_RECIP_W  = 32;
  localparam int PWM_FULL_W   = PWM_PROD_W + PWM_RECIP_W;
  localparam int PWM_Q_W      = PWM_FULL_W - PWM_SH;
  localparam longint unsigned PWM_RECIP =
    ((64'd1 << PWM_SH) + PWM_DIV - 1) / PWM_DIV;
  localparam logic [PWM_N_W-1:0] PWM_OFS = PWM_N_W'(819);

  typedef enum logic [2:0] {
    REG_CAL0       = 3'd0,
    REG_CAL1       = 3'd1,
    REG_CAL2       = 3'd2,
    REG_CAL3       = 3'd3,
    REG_SPIN_THR   = 3'd4,
    REG_LEAD       = 3'd5,
    REG_PWM_PERIOD = 3'd6
  } reg_idx_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_t;

  typedef struct packed {
    logic [SOLENOIDS-1:0][CAL_W-1:0] cal_angle;
    logic [THR_W-1:0]                spin_threshold;
    logic [LEAD_W-1:0]               lead_angle;
    logic [PERIOD_W-1:0]             pwm_period;
  } cfg_t;

  // item leaving the history stage
  typedef struct packed {
    logic [ANGLE_BITS-1:0] angle;
    logic [RAW_W-1:0]      raw;
    logic [ANGLE_BITS-1:0] oldest;
  } hist_t;

endpackage

[src/scc_in_if.sv]
`timescale 1ns / 1ps

interface scc_in_if;
  logic                            valid;
  logic                            ready;
  logic [scc_pkg::ANGLE_BITS-1:0]  shaft_angle;
  logic [scc_pkg::RAW_W-1:0]       throttle_raw;

  modport source (output valid, shaft_angle, throttle_raw, input ready);
  modport sink   (input valid, shaft_angle, throttle_raw, output ready);
endinterface

[src/scc_out_if.sv]
`timescale 1ns / 1ps

interface scc_out_if;
  logic                            valid;
  logic                            ready;
  logic [scc_pkg::SOLENOIDS-1:0]   solenoid_enables;
  logic [scc_pkg::DIR_W-1:0]       spin_dir;
  logic [scc_pkg::PERIOD_W-1:0]    pwm_compare;
  logic [scc_pkg::ANGLE_BITS-1:0]  predicted_angle;

  modport source (output valid, solenoid_enables, spin_dir, pwm_compare, predicted_angle,
                  input ready);
  modport sink   (input valid, solenoid_enables, spin_dir, pwm_compare, predicted_angle,
                  output ready);
endinterface

[src/solenoid_commutation_controller.sv]
`timescale 1ns / 1ps

// Solenoid commutation controller.
// in_ch carries one sensor tick per item: shaft_angle (16384 units per turn)
// and throttle_raw. out_ch returns one result item per tick: solenoid enables,
// spin direction, pwm compare value and the predicted next angle.
// Registers sit on an APB-style port at byte address 4*index: cal angles 0..3,
// then spin threshold, lead angle and pwm period; pready is always high.
// A result passes through registered stages in order: history read, window
// difference and products, prediction and pwm reciprocal product, result
// register. One item per cycle is sustained while out_ch is ready; the
// history RAM takes one write and one read per item, the two window products
// share the difference stage, the pwm reciprocal product the prediction stage.
// Reset clears the write pointer, the history valid bits (unwritten entries
// read as zero) and all registers to their defaults; in_ch.ready is low while
// reset is held. When out_ch stalls the result register holds its item and
// the stages behind it keep filling, so in_ch takes up to three more items
// before ready drops.
module solenoid_commutation_controller #(
  parameter int WINDOW = scc_pkg::WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  scc_in_if.sink                      in_ch,
  scc_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scc_pkg::ADDR_W-1:0]  paddr,
  input  logic [scc_pkg::DATA_W-1:0]  pwdata,
  output logic [scc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  scc_pkg::cfg_t  cfg;
  scc_pkg::hist_t a_data;
  logic           a_valid;
  logic           a_ready;

  scc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  scc_history #(.WINDOW(WINDOW)) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .a_ready (a_ready),
    .a_valid (a_valid),
    .a_data  (a_data)
  );

  scc_datapath #(.WINDOW(WINDOW)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .a_valid (a_valid),
    .a_data  (a_data),
    .a_ready (a_ready),
    .out_ch  (out_ch)
  );

endmodule

[src/scc_cfg_regs.sv]
`timescale 1ns / 1ps

module scc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scc_pkg::ADDR_W-1:0]    paddr,
  input  logic [scc_pkg::DATA_W-1:0]    pwdata,
  output logic [scc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output scc_pkg::cfg_t                 cfg
);

  scc_pkg::cfg_t    cfg_r;
  scc_pkg::reg_idx_t idx;
  logic             wr_en;

  assign idx    = scc_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cal_angle      <= '0;
      cfg_r.spin_threshold <= scc_pkg::SPIN_THR_RST;
      cfg_r.lead_angle     <= scc_pkg::LEAD_RST;
      cfg_r.pwm_period     <= scc_pkg::PWM_PERIOD_RST;
    end else if (wr_en) begin
      unique case (idx) inside
        scc_pkg::REG_CAL0, scc_pkg::REG_CAL1, scc_pkg::REG_CAL2, scc_pkg::REG_CAL3: begin
          cfg_r.cal_angle[paddr[3:2]] <= pwdata[scc_pkg::CAL_W-1:0];
        end
        scc_pkg::REG_SPIN_THR:   cfg_r.spin_threshold <= pwdata[scc_pkg::THR_W-1:0];
        scc_pkg::REG_LEAD:       cfg_r.lead_angle     <= pwdata[scc_pkg::LEAD_W-1:0];
        scc_pkg::REG_PWM_PERIOD: cfg_r.pwm_period     <= pwdata[scc_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx) inside
      scc_pkg::REG_CAL0, scc_pkg::REG_CAL1, scc_pkg::REG_CAL2, scc_pkg::REG_CAL3: begin
        prdata = scc_pkg::DATA_W'(cfg_r.cal_angle[paddr[3:2]]);
      end
      scc_pkg::REG_SPIN_THR:   prdata = scc_pkg::DATA_W'(cfg_r.spin_threshold);
      scc_pkg::REG_LEAD:       prdata = scc_pkg::DATA_W'(cfg_r.lead_angle);
      scc_pkg::REG_PWM_PERIOD: prdata = scc_pkg::DATA_W'(cfg_r.pwm_period);
      default:                 prdata = '0;
    endcase
  end

endmodule

[src/scc_history.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scc_history #(
  parameter int WINDOW = scc_pkg::WINDOW_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  scc_in_if.sink          in_ch,
  input  logic            a_ready,
  output logic            a_valid,
  output scc_pkg::hist_t  a_data
);

  localparam int A     = scc_pkg::ANGLE_BITS;
  localparam int PTR_W = $clog2(WINDOW);

  logic [A-1:0]       mem [WINDOW];
  logic [WINDOW-1:0]  hist_vld_r;
  logic [PTR_W-1:0]   wp_r;
  logic [PTR_W-1:0]   wp_nxt;
  logic               in_fire;

  logic                        a_valid_r;
  logic [A-1:0]                a_angle_r;
  logic [scc_pkg::RAW_W-1:0]   a_raw_r;
  logic [A-1:0]                a_old_r;
  logic                        a_old_ok_r;

  assign in_ch.ready = rst_n && (!a_valid_r || a_ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // slot after the one being written holds the sample from WINDOW-1 items back
  assign wp_nxt = (wp_r == PTR_W'(WINDOW - 1)) ? '0 : wp_r + 1'b1;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem[wp_r]  <= in_ch.shaft_angle;
      a_old_r    <= mem[wp_nxt];
      a_old_ok_r <= hist_vld_r[wp_nxt];
      a_angle_r  <= in_ch.shaft_angle;
      a_raw_r    <= in_ch.throttle_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      hist_vld_r <= '0;
      a_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        wp_r             <= wp_nxt;
        hist_vld_r[wp_r] <= 1'b1;
      end
      if (!a_valid_r || a_ready) begin
        a_valid_r <= in_fire;
      end
    end
  end

  assign a_valid       = a_valid_r;
  assign a_data.angle  = a_angle_r;
  assign a_data.raw    = a_raw_r;
  // never-written entries read as the reset value zero
  assign a_data.oldest = a_old_ok_r ? a_old_r : '0;

  `SCC_ASSERT(a_ptr_in_range, wp_r <= PTR_W'(WINDOW - 1), "write pointer out of range")
  `SCC_ASSERT(a_rd_ne_wr, wp_nxt != wp_r, "history read and write collide")
  `SCC_ASSERT_NEXT(a_fire_loads, in_fire, a_valid_r, "accepted item lost in history stage")

endmodule

[src/scc_datapath.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scc_datapath #(
  parameter int WINDOW = scc_pkg::WINDOW_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  scc_pkg::cfg_t   cfg,
  input  logic            a_valid,
  input  scc_pkg::hist_t  a_data,
  output logic            a_ready,
  scc_out_if.source       out_ch
);

  localparam int A  = scc_pkg::ANGLE_BITS;
  localparam int S  = scc_pkg::SOLENOIDS;
  localparam int DW = A + 2;
  localparam logic signed [DW-1:0] HALF_S = DW'(1 << (A - 1));
  localparam logic signed [DW-1:0] TURN_S = DW'(1 << A);

  // diff / (WINDOW-1) truncated, by reciprocal multiply on the magnitude
  localparam int DIV_D  = WINDOW - 1;
  localparam int DIV_SH = A + $clog2(DIV_D);
  localparam longint unsigned DIV_RECIP = ((64'd1 << DIV_SH) + DIV_D - 1) / DIV_D;
  localparam int PW = 2 * A + 1;

  function automatic logic signed [DW-1:0] wrap_diff(input logic signed [DW-1:0] d);
    logic signed [DW-1:0] r;
    r = d;
    if (r > HALF_S) r = r - TURN_S;
    if (r < -HALF_S) r = r + TURN_S;
    return r;
  endfunction

  logic b_ready, c_ready, d_ready;

  // stage b: window difference, direction, first products
  logic signed [DW-1:0]                 diff;
  logic signed [DW-1:0]                 mag;
  logic signed [DW-1:0]                 thr_s;
  scc_pkg::dir_t                        dir_nxt;
  logic [PW-1:0]                        div_nxt;
  logic [scc_pkg::PWM_N_W-1:0]          n4;
  logic [scc_pkg::PWM_N_W-1:0]          n_val;
  logic [scc_pkg::PWM_P1_W-1:0]         p1;
  logic [scc_pkg::PWM_PROD_W-1:0]       pwm_nxt;

  logic                                 b_valid_r;
  logic [A-1:0]                         b_angle_r;
  logic                                 b_neg_r;
  logic [PW-1:0]                        b_div_r;
  scc_pkg::dir_t                        b_dir_r;
  logic [scc_pkg::PWM_PROD_W-1:0]       b_pwm_r;

  always_comb begin
    diff    = wrap_diff($signed({2'b00, a_data.angle}) - $signed({2'b00, a_data.oldest}));
    mag     = diff[DW-1] ? -diff : diff;
    div_nxt = PW'(mag[A-1:0]) * PW'(DIV_RECIP);
    thr_s   = $signed(DW'(cfg.spin_threshold));
    if (diff > thr_s)       dir_nxt = scc_pkg::DIR_POS;
    else if (diff < -thr_s) dir_nxt = scc_pkg::DIR_NEG;
    else                    dir_nxt = scc_pkg::DIR_NONE;
    n4    = {a_data.raw, 2'b00};
    n_val = n4 - scc_pkg::PWM_OFS;
    p1    = {1'b0, cfg.pwm_period} + 1'b1;
    // zero throttle share or no spin gives compare zero
    if (n4 > scc_pkg::PWM_OFS && dir_nxt != scc_pkg::DIR_NONE) begin
      pwm_nxt = scc_pkg::PWM_PROD_W'(n_val) * scc_pkg::PWM_PROD_W'(p1);
    end else begin
      pwm_nxt = '0;
    end
  end

  assign b_ready = !b_valid_r || c_ready;
  assign a_ready = b_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid;
      if (a_valid) begin
        b_angle_r <= a_data.angle;
        b_neg_r   <= diff[DW-1];
        b_div_r   <= div_nxt;
        b_dir_r   <= dir_nxt;
        b_pwm_r   <= pwm_nxt;
      end
    end
  end

  // stage c: predicted angle, pwm reciprocal product
  logic [A-1:0]                   q;
  logic [A-1:0]                   step;
  logic [A-1:0]                   pred_nxt;
  logic [scc_pkg::PWM_FULL_W-1:0] pwm_full_nxt;

  logic                           c_valid_r;
  logic [A-1:0]                   c_pred_r;
  scc_pkg::dir_t                  c_dir_r;
  logic [scc_pkg::PWM_FULL_W-1:0] c_pwm_r;

  always_comb begin
    q            = A'(b_div_r >> DIV_SH);
    step         = b_neg_r ? (~q + 1'b1) : q;
    pred_nxt     = b_angle_r + step;
    pwm_full_nxt = scc_pkg::PWM_FULL_W'(b_pwm_r) * scc_pkg::PWM_FULL_W'(scc_pkg::PWM_RECIP);
  end

  assign c_ready = !c_valid_r || d_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (c_ready) begin
      c_valid_r <= b_valid_r;
      if (b_valid_r) begin
        c_pred_r <= pred_nxt;
        c_dir_r  <= b_dir_r;
        c_pwm_r  <= pwm_full_nxt;
      end
    end
  end

  // stage d: energise windows, pwm clamp, result register
  logic signed [DW-1:0]          lead_s;
  logic signed [DW-1:0]          hml;
  logic signed [DW-1:0]          rel [S];
  logic [S-1:0]                  en_nxt;
  logic [scc_pkg::PWM_Q_W-1:0]   cq;
  logic [scc_pkg::PERIOD_W-1:0]  cmp_nxt;

  logic                          d_valid_r;
  logic [S-1:0]                  d_en_r;
  scc_pkg::dir_t                 d_dir_r;
  logic [scc_pkg::PERIOD_W-1:0]  d_cmp_r;
  logic [A-1:0]                  d_pred_r;

  always_comb begin
    lead_s = $signed(DW'(cfg.lead_angle));
    hml    = HALF_S - lead_s;
    for (int i = 0; i < S; i++) begin
      rel[i] = wrap_diff($signed({2'b00, c_pred_r}) -
                         $signed({2'b00, A'(cfg.cal_angle[i])}));
      case (c_dir_r)
        scc_pkg::DIR_POS: en_nxt[i] = (rel[i] > -hml) && (rel[i] < -lead_s);
        scc_pkg::DIR_NEG: en_nxt[i] = (rel[i] > lead_s) && (rel[i] < hml);
        default:          en_nxt[i] = 1'b0;
      endcase
    end
    cq = scc_pkg::PWM_Q_W'(c_pwm_r >> scc_pkg::PWM_SH);
    if (cq > scc_pkg::PWM_Q_W'(cfg.pwm_period)) cmp_nxt = cfg.pwm_period;
    else                                         cmp_nxt = cq[scc_pkg::PERIOD_W-1:0];
  end

  assign d_ready = !d_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (d_ready) begin
      d_valid_r <= c_valid_r;
      if (c_valid_r) begin
        d_en_r   <= en_nxt;
        d_dir_r  <= c_dir_r;
        d_cmp_r  <= cmp_nxt;
        d_pred_r <= c_pred_r;
      end
    end
  end

  assign out_ch.valid            = d_valid_r;
  assign out_ch.solenoid_enables = d_en_r;
  assign out_ch.spin_dir         = d_dir_r;
  assign out_ch.pwm_compare      = d_cmp_r;
  assign out_ch.predicted_angle  = d_pred_r;

  `SCC_ASSERT(a_cmp_le_period, !d_valid_r || (d_cmp_r <= cfg.pwm_period),
              "pwm compare above period")
  `SCC_ASSERT(a_nospin_quiet,
              !d_valid_r || (d_dir_r != scc_pkg::DIR_NONE) || (d_en_r == '0 && d_cmp_r == '0),
              "output active without spin")

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import scc_pkg::*;

  localparam int WIN  = WINDOW_DEF;
  localparam int TURN = 1 << ANGLE_BITS;
  localparam int HALF = 1 << (ANGLE_BITS - 1);
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 75;

  typedef struct packed {
    logic [SOLENOIDS-1:0]  enables;
    dir_t                  dir;
    logic [PERIOD_W-1:0]   compare;
    logic [ANGLE_BITS-1:0] pred;
  } commutation_t;

  localparam commutation_t NO_RES = '{4'h0, DIR_NONE, 16'd0, 14'd0};

  typedef struct {
    bit                    is_cfg;
    reg_idx_t              ridx;
    logic [DATA_W-1:0]     wdata;
    logic [ANGLE_BITS-1:0] angle;
    logic [RAW_W-1:0]      raw;
    bit                    typed;
    commutation_t          want;
  } stim_row_t;

  localparam int PLAN_N = 28;

  // typed rows start from the reset state: empty history, default registers
  stim_row_t plan [PLAN_N] = '{
    '{1'b0, REG_CAL0, 32'd0, 14'd0, 12'd0, 1'b1, '{4'h0, DIR_NONE, 16'd0, 14'd0}},
    '{1'b0, REG_CAL0, 32'd0, 14'd0, 12'd4095, 1'b1, '{4'h0, DIR_NONE, 16'd0, 14'd0}},
    '{1'b0, REG_CAL0, 32'd0, 14'd8192, 12'd4095, 1'b1, '{4'h0, DIR_POS, 16'd999, 14'd8359}},
    '{1'b0, REG_CAL0, 32'd0, 14'd8193, 12'd204, 1'b1, '{4'h0, DIR_NEG, 16'd0, 14'd8026}},
    '{1'b0, REG_CAL0, 32'd0, 14'd22, 12'd300, 1'b1, '{4'h0, DIR_NONE, 16'd0, 14'd22}},
    '{1'b0, REG_CAL0, 32'd0, 14'd23, 12'd4095, 1'b1, '{4'h0, DIR_POS, 16'd999, 14'd23}},
    '{1'b0, REG_CAL0, 32'd0, 14'd16361, 12'd1024, 1'b0, NO_RES},
    '{1'b0, REG_CAL0, 32'd0, 14'd16362, 12'd2048, 1'b0, NO_RES},
    '{1'b0, REG_CAL0, 32'd0, 14'd16383, 12'd205, 1'b0, NO_RES},
    '{1'b0, REG_CAL0, 32'd0, 14'd1, 12'd3000, 1'b0, NO_RES},
    '{1'b1, REG_CAL0, 32'd8192, 14'd0, 12'd0, 1'b0, NO_RES},
    '{1'b1, REG_CAL1, 32'd16383, 14'd0, 12'd0, 1'b0, NO_RES},
    '{1'b1, REG_CAL2, 32'd4096, 14'd0, 12'd0, 1'b0, NO_RES},
    '{1'b1, REG_CAL3, 32'd12288, 14'd0, 12'd0, 1'b0, NO_RES},
    '{1'b1, REG_SPIN_THR, 32'd0, 14'd0, 12'd0, 1'b0, NO_RES},
    '{1'b1, REG_LEAD, 32'd0, 14'd0, 12'd0, 1'b0, NO_RES},
    '{1'b1, REG_PWM_PERIOD, 32'd65535, 14'd0, 12'd0, 1'b0, NO_RES},
    '{1'b0, REG_CAL0, 32'd0, 14'd4000, 12'd4095, 1'b0, NO_RES},
    '{1'b0, REG_CAL0, 32'd0, 14'd12000, 12'd2048, 1'b0, NO_RES},
    '{1'b0, REG_CAL0, 32'd0, 14'd16383, 12'd0, 1'b0, NO_RES},
    '{1'b0, REG_CAL0, 32'd0, 14'd8192, 12'd1, 1'b0, NO_RES},
    '{1'b0, REG_CAL0, 32'd0, 14'd100, 12'd4095, 1'b0, NO_RES},
    '{1'b1, REG_PWM_PERIOD, 32'd0, 14'd0, 12'd0, 1'b0, NO_RES},
    '{1'b1, REG_LEAD, 32'd4095, 14'd0, 12'd0, 1'b0, NO_RES},
    '{1'b1, REG_SPIN_THR, 32'd8191, 14'd0, 12'd0, 1'b0, NO_RES},
    '{1'b0, REG_CAL0, 32'd0, 14'd8192, 12'd4095, 1'b0, NO_RES},
    '{1'b0, REG_CAL0, 32'd0, 14'd0, 12'd4095, 1'b0, NO_RES},
    '{1'b0, REG_CAL0, 32'd0, 14'd16383, 12'd4095, 1'b0, NO_RES}
  };

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  scc_in_if  in_ch ();
  scc_out_if out_ch ();

  solenoid_commutation_controller dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor copy of registers and history
  logic [CAL_W-1:0]      tdc_angle [SOLENOIDS];
  logic [THR_W-1:0]      spin_thr;
  logic [LEAD_W-1:0]     lead;
  logic [PERIOD_W-1:0]   period;
  logic [ANGLE_BITS-1:0] angle_hist [WIN];
  int                    hist_ptr;

  commutation_t commutation_due [$];
  int bad_fields;
  int sender_pct;
  int recv_pct;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  function automatic int wrap_turn(int d);
    if (d > HALF) d -= TURN;
    if (d < -HALF) d += TURN;
    return d;
  endfunction

  function automatic commutation_t commutate(logic [ANGLE_BITS-1:0] a, logic [RAW_W-1:0] r);
    commutation_t res;
    logic [ANGLE_BITS-1:0] older;
    int diff, step, rel, ld;
    longint n, c;
    angle_hist[hist_ptr] = a;
    hist_ptr = (hist_ptr == WIN - 1) ? 0 : hist_ptr + 1;
    older = angle_hist[hist_ptr];
    diff = wrap_turn(int'(a) - int'(older));
    step = diff / (WIN - 1);
    res.pred = ANGLE_BITS'(int'(a) + step + TURN);
    if (diff > int'(spin_thr)) res.dir = DIR_POS;
    else if (diff < -int'(spin_thr)) res.dir = DIR_NEG;
    else res.dir = DIR_NONE;
    ld = int'(lead);
    res.enables = '0;
    for (int i = 0; i < SOLENOIDS; i++) begin
      rel = wrap_turn(int'(res.pred) - int'(tdc_angle[i]));
      if (res.dir == DIR_POS) res.enables[i] = (rel > -(HALF - ld)) && (rel < -ld);
      else if (res.dir == DIR_NEG) res.enables[i] = (rel > ld) && (rel < (HALF - ld));
    end
    res.compare = '0;
    if (res.dir != DIR_NONE) begin
      n = 4 * longint'(r) - 819;
      if (n > 0) begin
        c = (n * (longint'(period) + 1)) / 14742;
        if (c > longint'(period)) c = longint'(period);
        res.compare = PERIOD_W'(c);
      end
    end
    return res;
  endfunction

  task automatic send_tick(logic [ANGLE_BITS-1:0] a, logic [RAW_W-1:0] r, bit typed,
                           commutation_t want);
    commutation_t model;
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.shaft_angle  <= a;
    in_ch.throttle_raw <= r;
    do @(posedge clk); while (!in_ch.ready);
    model = commutate(a, r);
    commutation_due.push_back(typed ? want : model);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (commutation_due.size() != 0) @(posedge clk);
  endtask

  // block holds nothing once the last item is out, and idle clocks follow
  task automatic quiesce();
    hold_until_drained();
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [DATA_W-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_CAL0, REG_CAL1, REG_CAL2, REG_CAL3: tdc_angle[int'(idx)] = v[CAL_W-1:0];
      REG_SPIN_THR:   spin_thr = v[THR_W-1:0];
      REG_LEAD:       lead = v[LEAD_W-1:0];
      REG_PWM_PERIOD: period = v[PERIOD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [RAW_W-1:0] pick_throttle();
    case ($urandom_range(0, 7))
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'd204;
      3: return 12'd205;
      default: return RAW_W'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic configure_phase(int p);
    logic [DATA_W-1:0] vals [7];
    int widths [7];
    widths = '{CAL_W, CAL_W, CAL_W, CAL_W, THR_W, LEAD_W, PERIOD_W};
    if (p == 0) begin
      foreach (vals[i]) vals[i] = '0;
    end else if (p == 1) begin
      foreach (vals[i]) vals[i] = (32'd1 << widths[i]) - 1;
    end else begin
      for (int i = 0; i < SOLENOIDS; i++) vals[i] = $urandom_range(0, 16383);
      vals[4] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 300);
      vals[5] = $urandom_range(0, 4095);
      vals[6] = $urandom_range(0, 65535);
      // junk above the field must be dropped
      if (p % 3 == 2) begin
        foreach (vals[i]) vals[i] = vals[i] | (($urandom() >> widths[i]) << widths[i]);
      end
    end
    quiesce();
    for (int i = 0; i < 7; i++) cfg_write(reg_idx_t'(i), vals[i]);
  endtask

  task automatic run_phase(int budget);
    int sent, kind, len, speed, jitter;
    logic [ANGLE_BITS-1:0] ang;
    sent = 0;
    ang = ANGLE_BITS'($urandom_range(0, 16383));
    while (sent < budget) begin
      kind = $urandom_range(0, 9);
      speed = 0;
      if (kind <= 5) begin
        len = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0: speed = $urandom_range(0, 3);
          1: speed = int'(spin_thr) / (WIN - 1) + $urandom_range(0, 2);
          default: speed = $urandom_range(0, 167);
        endcase
        if ($urandom_range(0, 1)) speed = -speed;
      end else if (kind == 6) begin
        len = 55;
      end else begin
        len = $urandom_range(5, 20);
      end
      for (int k = 0; k < len && sent < budget; k++) begin
        if (kind <= 5) begin
          jitter = (kind == 5) ? $urandom_range(0, 2) - 1 : 0;
          ang = ang + ANGLE_BITS'(speed + jitter);
        end else if (kind == 6) begin
          // stand still a full window, then jump exactly half a turn
          if (k == WIN - 1) ang = ang + ANGLE_BITS'(HALF);
        end else begin
          ang = ANGLE_BITS'($urandom_range(0, 16383));
        end
        send_tick(ang, pick_throttle(), 1'b0, NO_RES);
        sent++;
        if (sent == budget / 2) hold_until_drained();
      end
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_pct);
    end
  end

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      bad_fields++;
    end
  endtask

  always @(posedge clk) begin : result_check
    commutation_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (commutation_due.size() == 0) begin
        $error("result item with nothing expected");
        bad_fields++;
      end else begin
        want = commutation_due.pop_front();
        check_field("solenoid_enables", want.enables, out_ch.solenoid_enables);
        check_field("spin_dir", want.dir, out_ch.spin_dir);
        check_field("pwm_compare", want.compare, out_ch.pwm_compare);
        check_field("predicted_angle", want.pred, out_ch.predicted_angle);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.shaft_angle = '0;
    in_ch.throttle_raw = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    bad_fields = 0;
    sender_pct = 0;
    recv_pct = 0;
    foreach (tdc_angle[i]) tdc_angle[i] = '0;
    spin_thr = SPIN_THR_RST;
    lead = LEAD_RST;
    period = PWM_PERIOD_RST;
    foreach (angle_hist[i]) angle_hist[i] = '0;
    hist_ptr = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        quiesce();
        cfg_write(plan[i].ridx, plan[i].wdata);
      end else begin
        send_tick(plan[i].angle, plan[i].raw, plan[i].typed, plan[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      configure_phase(p);
      sender_pct = (p % 4 == 1) ? 46 : (p % 4 == 3) ? 8 : 0;
      recv_pct   = (p % 4 == 2) ? 46 : (p % 4 == 3) ? 8 : 0;
      run_phase(PHASE_ITEMS);
    end

    hold_until_drained();
    repeat (20) @(posedge clk);
    if (bad_fields == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
